>>> rtl/tsfc_pkg.sv
// Shared types and codes for the touch-panel front end.
// No dependencies; every other rtl file imports this package.
package tsfc_pkg;

    // Panel state codes
    localparam logic [1:0] ST_IDLE      = 2'd0;
    localparam logic [1:0] ST_PRESAMPLE = 2'd1;
    localparam logic [1:0] ST_TOUCHED   = 2'd2;
    localparam logic [1:0] ST_RELEASED  = 2'd3;

    // Input action codes
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_PEN_DOWN = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 3;
    localparam logic [2:0]  CFG_CALIB_MODE = 3'd0;
    localparam logic [2:0]  CFG_COEF_XX    = 3'd1;
    localparam logic [2:0]  CFG_COEF_XY    = 3'd2;
    localparam logic [2:0]  CFG_OFFSET_X   = 3'd3;
    localparam logic [2:0]  CFG_COEF_YX    = 3'd4;
    localparam logic [2:0]  CFG_COEF_YY    = 3'd5;
    localparam logic [2:0]  CFG_OFFSET_Y   = 3'd6;

    // Datapath widths
    localparam int RAW_W  = 16;
    localparam int COEF_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = COEF_W + RAW_W + 1;   // signed coef * unsigned raw
    localparam int ACC_W  = PROD_W + 2;           // two products plus offset

    // Coefficient reset values (Q15.16)
    localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_ZERO = 32'sd0;

    typedef struct packed {
        logic [1:0]       action;
        logic             pen_up;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       panel_state;
        logic             touched;
        logic [RAW_W-1:0] avg_x;
        logic [RAW_W-1:0] avg_y;
        logic             pen_irq_enabled;
    } t_out_beat;

    // Panel status after one item
    typedef struct packed {
        logic [1:0] panel_state;
        logic       touched;
        logic       irq_armed;
    } t_status;

    // Affine calibration set
    typedef struct packed {
        logic signed [COEF_W-1:0] xx;
        logic signed [COEF_W-1:0] xy;
        logic signed [COEF_W-1:0] ox;
        logic signed [COEF_W-1:0] yx;
        logic signed [COEF_W-1:0] yy;
        logic signed [COEF_W-1:0] oy;
    } t_coef;

    // One X/Y sample word
    typedef struct packed {
        logic [RAW_W-1:0] x;
        logic [RAW_W-1:0] y;
    } t_point;

endpackage

>>> rtl/tsfc_ctrl.sv
// Panel state machine, write index and interrupt arming.
// Depends on tsfc_pkg.
module tsfc_ctrl
    import tsfc_pkg::*;
#(
    parameter int SAMPLE_COUNT = 8,
    parameter int IDX_W        = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in_beat         i_beat,
    output logic             o_store,
    output logic [IDX_W-1:0] o_idx,
    output t_status          o_status
);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_wi, n_wi;
    logic             r_irq, n_irq;
    logic             last;
    logic [IDX_W-1:0] inc;
    logic             store;

    // ring slot advance, wraps at the last slot
    assign last = (r_wi == IDX_W'(SAMPLE_COUNT - 1));
    assign inc  = last ? '0 : IDX_W'(r_wi + 1'b1);

    // next-state decode for one beat
    always_comb begin
        n_state = r_state;
        n_wi    = r_wi;
        n_irq   = r_irq;
        store   = 1'b0;
        case (i_beat.action)
            ACT_TICK: begin
                case (r_state)
                    ST_PRESAMPLE: begin
                        store = 1'b1;
                        n_wi  = inc;
                        if (last) begin
                            n_state = ST_TOUCHED;
                        end
                        if (i_beat.pen_up) begin
                            n_state = ST_RELEASED;
                        end
                    end
                    ST_TOUCHED: begin
                        store = 1'b1;
                        n_wi  = inc;
                        if (i_beat.pen_up) begin
                            n_state = ST_RELEASED;
                        end
                    end
                    ST_RELEASED: begin
                        n_state = ST_IDLE;
                        n_wi    = '0;
                        n_irq   = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            ACT_PEN_DOWN: begin
                // masked while disarmed
                if (r_irq) begin
                    n_irq   = 1'b0;
                    n_state = ST_PRESAMPLE;
                end
            end
            ACT_CLEAR: begin
                n_state = ST_PRESAMPLE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wi    <= '0;
            r_irq   <= 1'b1;
        end else if (i_accept) begin
            r_state <= n_state;
            r_wi    <= n_wi;
            r_irq   <= n_irq;
        end
    end

    assign o_store              = store;
    assign o_idx                = r_wi;
    assign o_status.panel_state = n_state;
    assign o_status.touched     = (n_state == ST_TOUCHED);
    assign o_status.irq_armed   = n_irq;

endmodule

>>> rtl/tsfc_affine.sv
// Two-stage affine correction: products, then sum, shift and saturate (raw pass-through in calibration mode).
// Depends on tsfc_pkg.
module tsfc_affine
    import tsfc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_load_b,
    input  logic   i_load_c,
    input  logic   i_calib,
    input  t_coef  i_coef,
    input  t_point i_raw,
    output t_point o_point
);

    logic signed [PROD_W-1:0] n_pxx, n_pxy, n_pyx, n_pyy;
    logic signed [PROD_W-1:0] r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [RAW_W:0]    sx, sy;
    t_point                   r_raw_b;
    logic signed [ACC_W-1:0]  acc_x, acc_y;
    t_point                   r_point;

    // Q34.16 sum to 16-bit unsigned, fraction truncated
    function automatic logic [RAW_W-1:0] sat16(input logic signed [ACC_W-1:0] a);
        logic [RAW_W-1:0] res;
        if (a[ACC_W-1]) begin
            res = '0;
        end else if (|a[ACC_W-2:FRAC_W+RAW_W]) begin
            res = '1;
        end else begin
            res = a[FRAC_W +: RAW_W];
        end
        return res;
    endfunction

    // stage B: four products, raw words are zero-extended to signed
    assign sx    = $signed({1'b0, i_raw.x});
    assign sy    = $signed({1'b0, i_raw.y});
    assign n_pxx = i_coef.xx * sx;
    assign n_pxy = i_coef.xy * sy;
    assign n_pyx = i_coef.yx * sx;
    assign n_pyy = i_coef.yy * sy;

    always_ff @(posedge i_clk) begin
        if (i_load_b) begin
            r_pxx   <= n_pxx;
            r_pxy   <= n_pxy;
            r_pyx   <= n_pyx;
            r_pyy   <= n_pyy;
            r_raw_b <= i_raw;
        end
    end

    // stage C: exact sum with offset, then clamp
    assign acc_x = ACC_W'(r_pxx) + ACC_W'(r_pxy) + ACC_W'(i_coef.ox);
    assign acc_y = ACC_W'(r_pyx) + ACC_W'(r_pyy) + ACC_W'(i_coef.oy);

    always_ff @(posedge i_clk) begin
        if (i_load_c) begin
            if (i_calib) begin
                r_point <= r_raw_b;
            end else begin
                r_point.x <= sat16(acc_x);
                r_point.y <= sat16(acc_y);
            end
        end
    end

    assign o_point = r_point;

endmodule

>>> rtl/tsfc_ring.sv
// Sample ring memory with running X/Y sums (read-modify-write).
// Depends on tsfc_pkg.
module tsfc_ring
    import tsfc_pkg::*;
#(
    parameter int SAMPLE_COUNT = 8,
    parameter int IDX_W        = 3,
    parameter int SUM_W        = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_point           i_wr_data,
    output logic [SUM_W-1:0] o_sum_x,
    output logic [SUM_W-1:0] o_sum_y
);

    t_point                  r_mem [SAMPLE_COUNT];
    logic [SAMPLE_COUNT-1:0] r_vld;
    t_point                  r_rd_q;
    logic                    r_old_vld;
    logic                    r_fwd;
    t_point                  r_fwd_data;
    t_point                  old;
    logic [SUM_W-1:0]        r_sum_x, r_sum_y;
    logic [SUM_W-1:0]        n_sum_x, n_sum_y;

    // memory ports: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q     <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // written flags and same-slot bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_old_vld <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_old_vld <= r_vld[i_rd_addr];
                r_fwd     <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    // old slot value: bypassed write, stored entry, or zero if never written
    assign old = r_fwd ? r_fwd_data : (r_old_vld ? r_rd_q : '0);

    // running sums; intermediate wrap cancels since the true sum fits
    assign n_sum_x = r_sum_x - SUM_W'(old.x) + SUM_W'(i_wr_data.x);
    assign n_sum_y = r_sum_y - SUM_W'(old.y) + SUM_W'(i_wr_data.y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (i_wr_en) begin
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
        end
    end

    assign o_sum_x = i_wr_en ? n_sum_x : r_sum_x;
    assign o_sum_y = i_wr_en ? n_sum_y : r_sum_y;

endmodule

>>> rtl/touch_sample_fsm_calibrated_core.sv
// Touch-panel front end top level: config registers, pipeline control, averaging.
// Depends on tsfc_pkg, tsfc_ctrl, tsfc_affine, tsfc_ring.
//
//  port group   dir  payload                       handshake
//  -----------  ---  ----------------------------  -----------------------
//  input beat   in   i_in_beat  (t_in_beat)        i_in_valid / o_in_ready
//  result beat  out  o_out_beat (t_out_beat)       o_out_valid / i_out_ready
//  config       in   i_cfg_index, i_cfg_data       i_cfg_valid / o_cfg_ready
//
// One beat per cycle sustained while the output is ready. Stages, in order:
// input register, products, sum and clamp with ring read, ring write-back with
// running sums, reciprocal multiply for the average. Same-slot ring overlap is
// bypassed, so no bubbles.
// Reset is synchronous; ring entries read as zero until written (no sweep).
// A stalled output holds every stage; input ready drops only when all are full.
module touch_sample_fsm_calibrated_core
    import tsfc_pkg::*;
#(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_beat,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    localparam int LOG_N  = $clog2(SAMPLE_COUNT);
    localparam int IDX_W  = (SAMPLE_COUNT > 1) ? LOG_N : 1;
    localparam int SUM_W  = LOG_N + RAW_W;
    localparam int SHIFT  = SUM_W + LOG_N;
    localparam int M_W    = SUM_W + 2;
    localparam int PROD_A = SUM_W + M_W;
    // ceil(2^SHIFT / N): exact floor division for any SUM_W-bit sum
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

    // configuration registers
    logic  r_calib;
    t_coef r_coef;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib   <= 1'b1;
            r_coef.xx <= COEF_ONE;
            r_coef.xy <= COEF_ZERO;
            r_coef.ox <= COEF_ZERO;
            r_coef.yx <= COEF_ZERO;
            r_coef.yy <= COEF_ONE;
            r_coef.oy <= COEF_ZERO;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CALIB_MODE: r_calib   <= i_cfg_data[0];
                CFG_COEF_XX:    r_coef.xx <= i_cfg_data;
                CFG_COEF_XY:    r_coef.xy <= i_cfg_data;
                CFG_OFFSET_X:   r_coef.ox <= i_cfg_data;
                CFG_COEF_YX:    r_coef.yx <= i_cfg_data;
                CFG_COEF_YY:    r_coef.yy <= i_cfg_data;
                CFG_OFFSET_Y:   r_coef.oy <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage occupancy and advance chain
    logic r_va, r_vb, r_vc, r_vd, r_vo;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
    logic in_acc, adv_b, adv_c, adv_d, adv_o;

    assign rdy_o  = !r_vo || i_out_ready;
    assign adv_o  = r_vd && rdy_o;
    assign rdy_d  = !r_vd || rdy_o;
    assign adv_d  = r_vc && rdy_d;
    assign rdy_c  = !r_vc || rdy_d;
    assign adv_c  = r_vb && rdy_c;
    assign rdy_b  = !r_vb || rdy_c;
    assign adv_b  = r_va && rdy_b;
    assign rdy_a  = !r_va || rdy_b;
    assign in_acc = i_in_valid && rdy_a;

    assign o_in_ready  = rdy_a;
    assign o_out_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_va <= in_acc || (r_va && !adv_b);
            r_vb <= adv_b  || (r_vb && !adv_c);
            r_vc <= adv_c  || (r_vc && !adv_d);
            r_vd <= adv_d  || (r_vd && !adv_o);
            r_vo <= adv_o  || (r_vo && !i_out_ready);
        end
    end

    // panel control, updated at acceptance
    logic             ctrl_store;
    logic [IDX_W-1:0] ctrl_idx;
    t_status          ctrl_status;

    tsfc_ctrl #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_beat   (i_in_beat),
        .o_store  (ctrl_store),
        .o_idx    (ctrl_idx),
        .o_status (ctrl_status)
    );

    // sideband carried along the pipe
    t_point           r_a_raw;
    logic             r_a_store, r_b_store, r_c_store;
    logic [IDX_W-1:0] r_a_idx, r_b_idx, r_c_idx;
    t_status          r_a_st, r_b_st, r_c_st, r_d_st;
    logic [SUM_W-1:0] r_d_sum_x, r_d_sum_y;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_raw.x <= i_in_beat.raw_x;
            r_a_raw.y <= i_in_beat.raw_y;
            r_a_store <= ctrl_store;
            r_a_idx   <= ctrl_idx;
            r_a_st    <= ctrl_status;
        end
        if (adv_b) begin
            r_b_store <= r_a_store;
            r_b_idx   <= r_a_idx;
            r_b_st    <= r_a_st;
        end
        if (adv_c) begin
            r_c_store <= r_b_store;
            r_c_idx   <= r_b_idx;
            r_c_st    <= r_b_st;
        end
    end

    // affine correction
    t_point corr;

    tsfc_affine u_affine (
        .i_clk    (i_clk),
        .i_load_b (adv_b),
        .i_load_c (adv_c),
        .i_calib  (r_calib),
        .i_coef   (r_coef),
        .i_raw    (r_a_raw),
        .o_point  (corr)
    );

    // ring: read slot entering C, write it back leaving C
    logic             ring_wr;
    logic [SUM_W-1:0] sum_x, sum_y;

    assign ring_wr = adv_d && r_c_store;

    tsfc_ring #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .IDX_W        (IDX_W),
        .SUM_W        (SUM_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (adv_c && r_b_store),
        .i_rd_addr (r_b_idx),
        .i_wr_en   (ring_wr),
        .i_wr_addr (r_c_idx),
        .i_wr_data (corr),
        .o_sum_x   (sum_x),
        .o_sum_y   (sum_y)
    );

    always_ff @(posedge i_clk) begin
        if (adv_d) begin
            r_d_sum_x <= sum_x;
            r_d_sum_y <= sum_y;
            r_d_st    <= r_c_st;
        end
    end

    // average: multiply by reciprocal, keep the integer part
    logic [PROD_A-1:0] prod_x, prod_y;

    assign prod_x = r_d_sum_x * RECIP;
    assign prod_y = r_d_sum_y * RECIP;

    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (adv_o) begin
            r_out.panel_state     <= r_d_st.panel_state;
            r_out.touched         <= r_d_st.touched;
            r_out.avg_x           <= prod_x[SHIFT +: RAW_W];
            r_out.avg_y           <= prod_y[SHIFT +: RAW_W];
            r_out.pen_irq_enabled <= r_d_st.irq_armed;
        end
    end

    assign o_out_beat = r_out;

    // checks
    a_clear_presample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_beat.action == ACT_CLEAR)
        |=> (r_a_st.panel_state == ST_PRESAMPLE) && !r_a_store)
        else $error("clear request did not enter presampling");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_idx <= IDX_W'(SAMPLE_COUNT - 1))
        else $error("ring write index out of range");

    a_store_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && ctrl_store |-> (ctrl_status.panel_state != ST_IDLE))
        else $error("sample stored while going idle");

endmodule
